// ----- hdl/savg_pkg.sv -----
package savg_pkg;

    // command codes
    localparam logic [1:0] CMD_RENDER = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;

    // attribute targets, screen byte bits 4..3
    localparam logic [1:0] ATTR_INK   = 2'd0;
    localparam logic [1:0] ATTR_TEXT  = 2'd1;
    localparam logic [1:0] ATTR_PAPER = 2'd2;
    localparam logic [1:0] ATTR_VIDEO = 2'd3;

    // screen memory bases
    localparam logic [15:0] HIRES_BASE      = 16'ha000;
    localparam logic [15:0] TEXT_BASE       = 16'hbb80;
    localparam logic [15:0] LOWER_TEXT_BASE = 16'hbf68;

    // charset store geometry
    localparam int GLYPH_DEPTH  = 4096;
    localparam int GLYPH_ADDR_W = 12;
    localparam int GLYPH_W      = 6;

    localparam logic [2:0] INK_RESET = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  line;
        logic [5:0]  column;
        logic [7:0]  screen_byte;
        logic [11:0] glyph_address;
        logic [5:0]  glyph_bits;
    } savg_in_t;

    typedef struct packed {
        logic [2:0]  pixel0;
        logic [2:0]  pixel1;
        logic [2:0]  pixel2;
        logic [2:0]  pixel3;
        logic [2:0]  pixel4;
        logic [2:0]  pixel5;
        logic [15:0] next_address;
    } savg_out_t;

    // cell after attribute decode, waiting for the charset read
    typedef struct packed {
        logic        use_glyph;
        logic [5:0]  direct_bits;
        logic [2:0]  fg;
        logic [2:0]  bg;
        logic [8:0]  next_line;
        logic [6:0]  next_column;
        logic        hires_now;
        logic        mode_hires;
    } stage_t;

endpackage

// ----- hdl/savg_ram.sv -----
module savg_ram
    import savg_pkg::*;
#(
    parameter int WIDTH = 6,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/savg_front.sv -----
module savg_front
    import savg_pkg::*;
#(
    parameter int GRAPHIC_LINES  = 200,
    parameter int CELLS_PER_LINE = 40,
    parameter int TOTAL_LINES    = 224
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  savg_in_t                s_data,
    input  logic                    out_free,
    output logic                    s1_valid,
    output stage_t                  s1_data,
    output logic                    ram_wr_en,
    output logic [GLYPH_ADDR_W-1:0] ram_wr_addr,
    output logic [GLYPH_W-1:0]      ram_wr_data,
    output logic                    ram_rd_en,
    output logic [GLYPH_ADDR_W-1:0] ram_rd_addr
);

    localparam logic [8:0] GRAPHIC_L = 9'(GRAPHIC_LINES);
    localparam logic [6:0] CELLS_L   = 7'(CELLS_PER_LINE);
    localparam logic [8:0] TOTAL_L   = 9'(TOTAL_LINES);

    logic [2:0] ink_reg, ink_next;
    logic [2:0] paper_reg, paper_next;
    logic [2:0] text_reg, text_next;
    logic [2:0] video_reg, video_next;
    logic [3:0] ticks_reg;
    logic       phase_reg;
    logic       hires_reg, hires_next;
    logic       s1_valid_reg;
    stage_t     s1_data_reg, s1_data_next;

    logic       render_acc, tick_acc, write_acc;
    logic       col0, graphic, is_attr, hires_cur;
    logic [2:0] ink_cur, paper_cur, text_cur, attr_val, fg, bg;
    logic [2:0] glyph_row;
    logic [3:0] ticks_inc;

    // one request per cycle while stage one can move on
    assign s_ready    = !s1_valid_reg || out_free;
    assign render_acc = s_valid && s_ready && (s_data.command == CMD_RENDER);
    assign tick_acc   = s_valid && s_ready && (s_data.command == CMD_TICK);
    assign write_acc  = s_valid && s_ready && (s_data.command == CMD_WRITE);

    // line start defaults and frame latch
    always_comb begin
        col0      = (s_data.column == 6'd0);
        graphic   = ({1'b0, s_data.line} < GRAPHIC_L);
        is_attr   = (s_data.screen_byte[6:5] == 2'b00);
        attr_val  = s_data.screen_byte[2:0];
        ink_cur   = col0 ? INK_RESET : ink_reg;
        paper_cur = col0 ? 3'd0 : paper_reg;
        text_cur  = col0 ? 3'd0 : text_reg;
        hires_cur = (col0 && (s_data.line == 8'd0)) ? video_reg[2] : hires_reg;
    end

    // attribute decode
    always_comb begin
        ink_next   = ink_cur;
        paper_next = paper_cur;
        text_next  = text_cur;
        video_next = video_reg;
        hires_next = hires_cur;
        if (is_attr) begin
            unique case (s_data.screen_byte[4:3])
                ATTR_INK:   ink_next   = attr_val;
                ATTR_TEXT:  text_next  = attr_val;
                ATTR_PAPER: paper_next = attr_val;
                ATTR_VIDEO: video_next = attr_val;
            endcase
            if (graphic) begin
                hires_next = video_next[2];
            end
        end
    end

    // colours, glyph row and raster step
    always_comb begin
        glyph_row = text_cur[1] ? {s_data.line[3], s_data.line[2:1]} : s_data.line[2:0];
        fg = (text_next[2] && phase_reg) ? paper_next : ink_next;
        bg = paper_next;
        if (s_data.screen_byte[7]) begin
            fg = ~fg;
            bg = ~bg;
        end
        s1_data_next.use_glyph   = !is_attr && !(hires_cur && graphic);
        s1_data_next.direct_bits = is_attr ? 6'd0 : s_data.screen_byte[5:0];
        s1_data_next.fg          = fg;
        s1_data_next.bg          = bg;
        s1_data_next.next_column = {1'b0, s_data.column} + 7'd1;
        s1_data_next.next_line   = {1'b0, s_data.line};
        if (s1_data_next.next_column >= CELLS_L) begin
            s1_data_next.next_column = 7'd0;
            s1_data_next.next_line   = {1'b0, s_data.line} + 9'd1;
        end
        s1_data_next.hires_now  = hires_next;
        s1_data_next.mode_hires = video_next[2];
        // lines past the frame wrap to line zero of the current mode
        if (s1_data_next.next_line >= TOTAL_L) begin
            s1_data_next.next_line = TOTAL_L;
        end
    end

    assign ticks_inc = ticks_reg + 4'd1;

    // charset store access
    assign ram_wr_en   = write_acc;
    assign ram_wr_addr = s_data.glyph_address;
    assign ram_wr_data = s_data.glyph_bits;
    assign ram_rd_en   = render_acc;
    assign ram_rd_addr = {video_reg[2], text_cur[0], s_data.screen_byte[6:0], glyph_row};

    // attribute state and flash timer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ink_reg      <= INK_RESET;
            paper_reg    <= 3'd0;
            text_reg     <= 3'd0;
            video_reg    <= 3'd0;
            ticks_reg    <= 4'd0;
            phase_reg    <= 1'b0;
            hires_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (render_acc) begin
                ink_reg   <= ink_next;
                paper_reg <= paper_next;
                text_reg  <= text_next;
                video_reg <= video_next;
                hires_reg <= hires_next;
            end
            if (tick_acc) begin
                ticks_reg <= ticks_inc;
                if (ticks_inc == 4'd0) begin
                    phase_reg <= ~phase_reg;
                end
            end
            if (render_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (out_free) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stage one payload
    always_ff @(posedge aclk) begin
        if (render_acc) begin
            s1_data_reg <= s1_data_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

endmodule

// ----- hdl/savg_render.sv -----
module savg_render
    import savg_pkg::*;
#(
    parameter int GRAPHIC_LINES  = 200,
    parameter int CELLS_PER_LINE = 40,
    parameter int TOTAL_LINES    = 224
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s1_valid,
    input  stage_t             s1_data,
    input  logic [GLYPH_W-1:0] glyph_data,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output savg_out_t          m_data
);

    localparam logic [8:0]  GRAPHIC_L = 9'(GRAPHIC_LINES);
    localparam logic [8:0]  TOTAL_L   = 9'(TOTAL_LINES);
    localparam logic [15:0] CELLS_W   = 16'(CELLS_PER_LINE);

    logic        m_valid_reg;
    savg_out_t   m_data_reg, m_data_next;
    logic [5:0]  bits;
    logic [8:0]  row_term;
    logic [15:0] base, offset;

    assign out_free = !m_valid_reg || m_ready;

    // pixel expansion, data bit 5 is leftmost
    always_comb begin
        bits = s1_data.use_glyph ? glyph_data : s1_data.direct_bits;
        m_data_next.pixel0 = bits[5] ? s1_data.fg : s1_data.bg;
        m_data_next.pixel1 = bits[4] ? s1_data.fg : s1_data.bg;
        m_data_next.pixel2 = bits[3] ? s1_data.fg : s1_data.bg;
        m_data_next.pixel3 = bits[2] ? s1_data.fg : s1_data.bg;
        m_data_next.pixel4 = bits[1] ? s1_data.fg : s1_data.bg;
        m_data_next.pixel5 = bits[0] ? s1_data.fg : s1_data.bg;
    end

    // next fetch address: pick row, one constant multiply, then add base and column
    always_comb begin
        if (s1_data.next_line >= GRAPHIC_L) begin
            row_term = (s1_data.next_line - GRAPHIC_L) >> 3;
            base     = LOWER_TEXT_BASE;
        end else if (s1_data.hires_now) begin
            row_term = s1_data.next_line;
            base     = HIRES_BASE;
        end else begin
            row_term = s1_data.next_line >> 3;
            base     = TEXT_BASE;
        end
        offset = 16'(16'(row_term) * CELLS_W);
        if (s1_data.next_line >= TOTAL_L) begin
            m_data_next.next_address = s1_data.mode_hires ? HIRES_BASE : TEXT_BASE;
        end else begin
            m_data_next.next_address = base + offset + 16'(s1_data.next_column);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hdl/serial_attribute_video_generator_core.sv -----
// serial attribute video generator
// s_ channel: one request per cell (render), per flash tick, or per charset
// store write; command selects which. only render requests produce a result.
// m_ channel: six 3-bit pixels, leftmost first, plus the address of the next
// screen byte in raster order.
// pipeline: a render request's attribute decode and charset read are
// registered in stage one, then its pixels and next-byte address go into
// the result register.
// throughput: one request per cycle; s_ready stays high while the result
// register is free or being drained, and stage one and the result register
// together hold two cells when m_ready is low. s_ready drops only once both
// are full, so nothing is lost while the receiver stalls.
// reset: ink white, paper black, text modes off, text video mode, flash timer
// cleared, frame base at text memory. the charset store is not cleared and
// must be written before glyph cells that use it are rendered.
// the charset store is a 4096 x 6 memory with one write and one
// registered read port.
module serial_attribute_video_generator_core
    import savg_pkg::*;
#(
    parameter int CELLS_PER_LINE = 40,
    parameter int TOTAL_LINES    = 224,
    parameter int GRAPHIC_LINES  = 200
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  savg_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output savg_out_t m_data
);

    logic                    out_free;
    logic                    s1_valid;
    stage_t                  s1_data;
    logic                    ram_wr_en, ram_rd_en;
    logic [GLYPH_ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [GLYPH_W-1:0]      ram_wr_data, ram_rd_data;

    // attribute state, decode and charset address
    savg_front #(
        .GRAPHIC_LINES  (GRAPHIC_LINES),
        .CELLS_PER_LINE (CELLS_PER_LINE),
        .TOTAL_LINES    (TOTAL_LINES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .out_free    (out_free),
        .s1_valid    (s1_valid),
        .s1_data     (s1_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    // charset store
    savg_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // pixels, next address and result register
    savg_render #(
        .GRAPHIC_LINES  (GRAPHIC_LINES),
        .CELLS_PER_LINE (CELLS_PER_LINE),
        .TOTAL_LINES    (TOTAL_LINES)
    ) u_render (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s1_valid   (s1_valid),
        .s1_data    (s1_data),
        .glyph_data (ram_rd_data),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- hdl/savg_checker.sv -----
module savg_checker
    import savg_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input savg_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input savg_out_t m_data
);

    // result channel empty after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // a free or draining result register never blocks new requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("request blocked while result side free");

    // every fresh result comes from an earlier accepted render request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_data.command == CMD_RENDER), 2))
        else $error("result without a render request");

endmodule

bind serial_attribute_video_generator_core savg_checker u_savg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- verif/serial_attribute_video_generator_checker.sv -----
`timescale 1ns / 100ps
module serial_attribute_video_generator_checker
    import savg_pkg::*;
#(
    parameter int CELLS_PER_LINE = 40,
    parameter int TOTAL_LINES    = 224,
    parameter int GRAPHIC_LINES  = 200
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  savg_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  savg_out_t m_data,
    output int        fail_count,
    output int        pending
);

    // shadow of the generator state
    logic [2:0]  ink;
    logic [2:0]  paper;
    logic [2:0]  text_modes;
    logic [2:0]  video_mode;
    logic [3:0]  tick_count;
    logic        flash_on;
    logic [15:0] frame_base;
    logic        hires_frame;
    logic [5:0]  charset [GLYPH_DEPTH];

    savg_out_t awaited_cells [$];
    int        mismatches = 0;

    function automatic logic [15:0] base_for_mode();
        return video_mode[2] ? HIRES_BASE : TEXT_BASE;
    endfunction

    function automatic logic [15:0] addr_of(input int ln, input int col);
        int a;
        if (ln >= GRAPHIC_LINES) begin
            a = int'(LOWER_TEXT_BASE) + ((ln - GRAPHIC_LINES) >> 3) * CELLS_PER_LINE + col;
        end else if (hires_frame) begin
            a = int'(frame_base) + ln * CELLS_PER_LINE + col;
        end else begin
            a = int'(frame_base) + (ln >> 3) * CELLS_PER_LINE + col;
        end
        return a[15:0];
    endfunction

    task automatic latch_frame();
        frame_base  = base_for_mode();
        hires_frame = video_mode[2];
    endtask

    // advance the shadow state by one request, queue the cell it renders
    task automatic apply_request(input savg_in_t req);
        logic [7:0]  c;
        logic [5:0]  bits;
        logic [2:0]  fg;
        logic [2:0]  bg;
        logic [2:0]  row;
        logic [11:0] idx;
        int          next_ln;
        int          next_col;
        savg_out_t   want_out;
        c = req.screen_byte;
        case (req.command)
            CMD_TICK: begin
                tick_count = tick_count + 4'd1;
                if (tick_count == 4'd0) flash_on = !flash_on;
            end
            CMD_WRITE: begin
                charset[req.glyph_address] = req.glyph_bits;
            end
            CMD_RENDER: begin
                // line start clears colours and text modes
                if (req.column == 6'd0) begin
                    ink        = INK_RESET;
                    paper      = 3'd0;
                    text_modes = 3'd0;
                    if (req.line == 8'd0) latch_frame();
                end
                // attribute, hires data or glyph row
                if (c[6:5] == 2'b00) begin
                    case (c[4:3])
                        ATTR_INK:   ink        = c[2:0];
                        ATTR_TEXT:  text_modes = c[2:0];
                        ATTR_PAPER: paper      = c[2:0];
                        ATTR_VIDEO: video_mode = c[2:0];
                        default: ;
                    endcase
                    bits = 6'd0;
                    if (req.line < GRAPHIC_LINES) latch_frame();
                end else if (hires_frame && req.line < GRAPHIC_LINES) begin
                    bits = c[5:0];
                end else begin
                    row = req.line[2:0];
                    if (text_modes[1]) row = {req.line[3], req.line[2:1]};
                    idx  = {video_mode[2], text_modes[0], c[6:0], row};
                    bits = charset[idx];
                end
                // colours, flash hides the foreground
                bg = paper;
                fg = (text_modes[2] && flash_on) ? paper : ink;
                if (c[7]) begin
                    fg = ~fg;
                    bg = ~bg;
                end
                want_out.pixel0 = bits[5] ? fg : bg;
                want_out.pixel1 = bits[4] ? fg : bg;
                want_out.pixel2 = bits[3] ? fg : bg;
                want_out.pixel3 = bits[2] ? fg : bg;
                want_out.pixel4 = bits[1] ? fg : bg;
                want_out.pixel5 = bits[0] ? fg : bg;
                // next cell in raster order
                next_col = int'(req.column) + 1;
                next_ln  = int'(req.line);
                if (next_col >= CELLS_PER_LINE) begin
                    next_col = 0;
                    next_ln  = next_ln + 1;
                end
                want_out.next_address = (next_ln >= TOTAL_LINES) ? base_for_mode()
                                                                 : addr_of(next_ln, next_col);
                awaited_cells.push_back(want_out);
            end
            default: ;
        endcase
    endtask

    task automatic check_cell(input savg_out_t got);
        savg_out_t want;
        if (awaited_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: cell result with none awaited: %h", $time, got);
            return;
        end
        want = awaited_cells.pop_front();
        if (got.pixel0 !== want.pixel0 || got.pixel1 !== want.pixel1 ||
            got.pixel2 !== want.pixel2 || got.pixel3 !== want.pixel3 ||
            got.pixel4 !== want.pixel4 || got.pixel5 !== want.pixel5 ||
            got.next_address !== want.next_address) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: cell mismatch: expected px %0d %0d %0d %0d %0d %0d addr %h",
                         $time, want.pixel0, want.pixel1, want.pixel2, want.pixel3,
                         want.pixel4, want.pixel5, want.next_address);
                $display("%0t:                got px %0d %0d %0d %0d %0d %0d addr %h",
                         $time, got.pixel0, got.pixel1, got.pixel2, got.pixel3,
                         got.pixel4, got.pixel5, got.next_address);
            end
        end
    endtask

    // watch both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            ink         = INK_RESET;
            paper       = 3'd0;
            text_modes  = 3'd0;
            video_mode  = 3'd0;
            tick_count  = 4'd0;
            flash_on    = 1'b0;
            frame_base  = TEXT_BASE;
            hires_frame = 1'b0;
            awaited_cells.delete();
        end else begin
            if (s_valid && s_ready) apply_request(s_data);
            if (m_valid && m_ready) check_cell(m_data);
        end
        fail_count <= mismatches;
        pending    <= awaited_cells.size();
    end

endmodule

// ----- verif/serial_attribute_video_generator_core_test.sv -----
`timescale 1ns / 100ps
module serial_attribute_video_generator_core_test;
    import savg_pkg::*;

    localparam int CELLS_PER_LINE  = 40;
    localparam int TOTAL_LINES     = 224;
    localparam int GRAPHIC_LINES   = 200;
    localparam int RANDOM_REQUESTS = 600;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int GLYPH_CHARS     = 8;

    // unused command code, the block drops it
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    savg_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    savg_out_t m_data;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int sent      = 0;
    int fail_count;
    int pending;

    serial_attribute_video_generator_core #(
        .CELLS_PER_LINE(CELLS_PER_LINE),
        .TOTAL_LINES   (TOTAL_LINES),
        .GRAPHIC_LINES (GRAPHIC_LINES)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    serial_attribute_video_generator_checker #(
        .CELLS_PER_LINE(CELLS_PER_LINE),
        .TOTAL_LINES   (TOTAL_LINES),
        .GRAPHIC_LINES (GRAPHIC_LINES)
    ) cell_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic savg_in_t make_req(input logic [1:0] cmd, input logic [7:0] ln,
                                          input logic [5:0] col, input logic [7:0] sb);
        savg_in_t r;
        r.command       = cmd;
        r.line          = ln;
        r.column        = col;
        r.screen_byte   = sb;
        r.glyph_address = 12'($urandom_range(4095));
        r.glyph_bits    = 6'($urandom_range(63));
        return r;
    endfunction

    function automatic savg_in_t make_write(input logic [11:0] addr, input logic [5:0] bits);
        savg_in_t r;
        r               = make_req(CMD_WRITE, 8'($urandom_range(255)), 6'($urandom_range(63)),
                                   8'($urandom_range(255)));
        r.glyph_address = addr;
        r.glyph_bits    = bits;
        return r;
    endfunction

    // characters that shape cells use, all of them written in the store
    function automatic logic [6:0] glyph_char(input int k);
        case (k)
            0:       return 7'h20;
            1:       return 7'h2a;
            2:       return 7'h3f;
            3:       return 7'h41;
            4:       return 7'h55;
            5:       return 7'h60;
            6:       return 7'h75;
            default: return 7'h7f;
        endcase
    endfunction

    function automatic logic [7:0] attr_byte();
        logic [7:0] b;
        b      = 8'($urandom_range(255));
        b[6:5] = 2'b00;
        return b;
    endfunction

    function automatic logic [7:0] shape_byte();
        return {1'($urandom_range(1)), glyph_char(int'($urandom_range(GLYPH_CHARS - 1)))};
    endfunction

    function automatic logic [7:0] pick_line();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'(GRAPHIC_LINES - 1);
            2, 3:    return 8'($urandom_range(GRAPHIC_LINES, TOTAL_LINES - 1));
            4:       return 8'($urandom_range(TOTAL_LINES, 255));
            default: return 8'($urandom_range(1, GRAPHIC_LINES - 2));
        endcase
    endfunction

    // one request, with sender idling in front of it
    task automatic send(input savg_in_t r);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (r.command != CMD_NONE) sent++;
    endtask

    task automatic noise();
        send(make_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                      6'($urandom_range(63)),
                      ($urandom_range(1) == 0) ? attr_byte() : shape_byte()));
    endtask

    // a run of cells in raster order, with ticks and store writes mixed in
    task automatic raster_run();
        logic [7:0] ln;
        logic [5:0] col;
        int         len;
        ln  = pick_line();
        col = ($urandom_range(9) < 6) ? 6'd0 : 6'($urandom_range(CELLS_PER_LINE - 1));
        len = $urandom_range(1, 48);
        repeat (len) begin
            if ($urandom_range(99) < 8) begin
                send(make_req(CMD_TICK, 8'($urandom_range(255)), 6'($urandom_range(63)),
                              8'($urandom_range(255))));
            end else if ($urandom_range(99) < 4) begin
                send(make_write(12'($urandom_range(4095)), 6'($urandom_range(63))));
            end
            send(make_req(CMD_RENDER, ln, col,
                          ($urandom_range(99) < 30) ? attr_byte() : shape_byte()));
            if (col >= 6'(CELLS_PER_LINE - 1)) begin
                col = 6'd0;
                ln  = (ln >= 8'(TOTAL_LINES - 1)) ? 8'd0 : ln + 8'd1;
            end else begin
                col = col + 6'd1;
            end
        end
    endtask

    initial begin
        int base;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every store row of the characters in use, then run the flash
        // timer to its hidden phase
        for (int bank = 0; bank < 2; bank++) begin
            for (int alt = 0; alt < 2; alt++) begin
                for (int ch = 0; ch < GLYPH_CHARS; ch++) begin
                    for (int row = 0; row < 8; row++) begin
                        send(make_write({1'(bank), 1'(alt), glyph_char(ch), 3'(row)},
                                        6'($urandom_range(63))));
                    end
                end
            end
        end
        repeat (16) send(make_req(CMD_TICK, 8'd0, 6'd0, 8'd0));

        // directed cells
        send(make_req(CMD_NONE, 8'hff, 6'h3f, 8'hff));
        send(make_req(CMD_RENDER, 8'd0, 6'd0, 8'h41));
        send(make_req(CMD_RENDER, 8'd0, 6'd1, 8'h01));
        send(make_req(CMD_RENDER, 8'd0, 6'd2, 8'h92));
        send(make_req(CMD_RENDER, 8'd0, 6'd3, 8'h0c));
        send(make_req(CMD_RENDER, 8'd9, 6'd4, 8'hff));
        send(make_req(CMD_RENDER, 8'd0, 6'd5, 8'h0b));
        send(make_req(CMD_RENDER, 8'd0, 6'd6, 8'h7f));
        // store write read back at once
        send(make_write(12'h20b, 6'h2a));
        send(make_req(CMD_RENDER, 8'd3, 6'd0, 8'h41));
        // hires mode, lower text lines, frame and screen wrap
        send(make_req(CMD_RENDER, 8'd5, 6'd7, 8'h1c));
        send(make_req(CMD_RENDER, 8'd5, 6'd8, 8'h3f));
        send(make_req(CMD_RENDER, 8'd5, 6'd9, 8'he0));
        send(make_req(CMD_RENDER, 8'd199, 6'd39, 8'h75));
        send(make_req(CMD_RENDER, 8'd210, 6'd10, 8'h41));
        send(make_req(CMD_RENDER, 8'd0, 6'd0, 8'h1f));
        send(make_req(CMD_RENDER, 8'd223, 6'd39, 8'h7f));
        send(make_req(CMD_RENDER, 8'd0, 6'd20, 8'h18));
        send(make_req(CMD_RENDER, 8'd255, 6'd63, 8'hff));
        send(make_req(CMD_RENDER, 8'd224, 6'd40, 8'h20));
        send(make_req(CMD_RENDER, 8'd100, 6'd39, 8'h00));

        // random requests over the idling phases, twice round
        base = sent;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            while (sent < base + (phase + 1) * RANDOM_REQUESTS / 8) begin
                if ($urandom_range(3) == 0) noise();
                else raster_run();
            end
        end

        // drain
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/savg_pkg.sv
hdl/savg_ram.sv
hdl/savg_front.sv
hdl/savg_render.sv
hdl/serial_attribute_video_generator_core.sv
hdl/savg_checker.sv
verif/serial_attribute_video_generator_checker.sv
verif/serial_attribute_video_generator_core_test.sv
